[rtl/lspr_pkg.sv]
`default_nettype none
package lspr_pkg;

  localparam int unsigned SpotDepthDefault   = 2048;
  localparam int unsigned HeaderBytesDefault = 27;

  localparam logic [15:0] PosLimit = 16'hFFFF;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic RESP_STATUS = 1'b0;
  localparam logic RESP_SPOT   = 1'b1;

  // One request as handed from the parser to the frame engine.
  typedef struct packed {
    logic        has_word;
    logic        has_end;
    logic        is_read;
    logic        is_long;
    logic        is_type1;
    logic [14:0] word_idx;
    logic [15:0] word;
    logic [7:0]  part_num;
    logic [7:0]  total_parts;
    logic [15:0] spot_total;
    logic [31:0] first_angle;
    logic [31:0] delta_angle;
    logic [15:0] sequence_num;
    logic [10:0] read_idx;
  } op_t;

endpackage
`default_nettype wire

[rtl/lspr_front.sv]
`default_nettype none
module lspr_front
  import lspr_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HeaderBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [10:0] spot_index_i,
  input  wire logic        q_ready_i,
  output logic             q_push_o,
  output op_t              q_op_o
);

  logic [15:0] pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  total_q, total_d;
  logic [7:0]  part_q, part_d;
  logic [15:0] spots_q, spots_d;
  logic [31:0] first_q, first_d;
  logic [31:0] delta_q, delta_d;
  logic [7:0]  hold_q, hold_d;
  logic        take;
  logic        is_byte;
  logic        in_data;
  logic [15:0] k;
  logic        word_now;

  assign in_ready_o = q_ready_i;
  assign take       = in_valid_i && q_ready_i;
  assign is_byte    = (req_type_i == REQ_BYTE);
  assign in_data    = (pos_q >= 16'(HEADER_BYTES));
  assign k          = pos_q - 16'(HEADER_BYTES);
  assign word_now   = (pos_q < PosLimit) && in_data && k[0];

  always_comb begin
    pos_d   = pos_q;
    type_d  = type_q;
    seq_d   = seq_q;
    total_d = total_q;
    part_d  = part_q;
    spots_d = spots_q;
    first_d = first_q;
    delta_d = delta_q;
    hold_d  = hold_q;
    if (take && is_byte) begin
      if (pos_q < PosLimit) begin
        // capture header fields by position
        if (pos_q == 16'd0) type_d = data_byte_i;
        else if (pos_q == 16'd9 || pos_q == 16'd10) seq_d = {seq_q[7:0], data_byte_i};
        else if (pos_q == 16'd11) total_d = data_byte_i;
        else if (pos_q == 16'd12) part_d = data_byte_i;
        else if (pos_q == 16'd15 || pos_q == 16'd16) spots_d = {spots_q[7:0], data_byte_i};
        else if (pos_q >= 16'd17 && pos_q <= 16'd20) first_d = {first_q[23:0], data_byte_i};
        else if (pos_q >= 16'd21 && pos_q <= 16'd24) delta_d = {delta_q[23:0], data_byte_i};
        if (in_data && !k[0]) hold_d = data_byte_i;
        pos_d = pos_q + 16'd1;
      end
      if (last_byte_i) pos_d = 16'd0;
    end
  end

  always_comb begin
    q_op_o.has_word     = is_byte && word_now;
    q_op_o.has_end      = is_byte && last_byte_i;
    q_op_o.is_read      = !is_byte;
    q_op_o.is_long      = in_data;
    q_op_o.is_type1     = (type_d == 8'd1);
    q_op_o.word_idx     = k[15:1];
    q_op_o.word         = {hold_q, data_byte_i};
    q_op_o.part_num     = part_d;
    q_op_o.total_parts  = total_d;
    q_op_o.spot_total   = spots_d;
    q_op_o.first_angle  = first_d;
    q_op_o.delta_angle  = delta_d;
    q_op_o.sequence_num = seq_d;
    q_op_o.read_idx     = spot_index_i;
    q_push_o = take && (!is_byte || word_now || last_byte_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      type_q  <= '0;
      seq_q   <= '0;
      total_q <= '0;
      part_q  <= '0;
      spots_q <= '0;
      first_q <= '0;
      delta_q <= '0;
      hold_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      type_q  <= type_d;
      seq_q   <= seq_d;
      total_q <= total_d;
      part_q  <= part_d;
      spots_q <= spots_d;
      first_q <= first_d;
      delta_q <= delta_d;
      hold_q  <= hold_d;
    end
  end

endmodule
`default_nettype wire

[rtl/lspr_queue.sv]
`default_nettype none
module lspr_queue
  import lspr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  op_t       data_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       data_o
);

  op_t        slot_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

[rtl/lspr_back.sv]
`default_nettype none
module lspr_back
  import lspr_pkg::*;
#(
  parameter int unsigned SPOT_DEPTH = SpotDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  op_t              q_op_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             resp_kind_o,
  output logic             frame_done_o,
  output logic             assembled_o,
  output logic [31:0]      total_messages_o,
  output logic [31:0]      lost_messages_o,
  output logic signed [31:0] start_angle_o,
  output logic signed [31:0] step_angle_o,
  output logic [11:0]      spot_count_o,
  output logic [15:0]      distance_o,
  output logic [15:0]      pulse_width_o
);

  localparam int unsigned AW  = $clog2(SPOT_DEPTH);
  localparam int unsigned SPW = AW + 1;
  localparam int unsigned ASW = ((SPW > 16) ? SPW : 16) + 1;

  logic [15:0] dist_mem  [SPOT_DEPTH];
  logic [15:0] pulse_mem [SPOT_DEPTH];

  logic [7:0]     exp_q, exp_d;
  logic [SPW-1:0] spots_q, spots_d;
  logic [31:0]    start_q, start_d, step_q, step_d;
  logic [31:0]    msgs_q, msgs_d, gaps_q, gaps_d;
  logic [15:0]    prev_q, prev_d;
  logic           first_q, first_d;

  logic           out_valid_q;
  logic           kind_q, done_q, asm_q;
  logic [31:0]    tot_q, lost_q, st_q, sp_q;
  logic [11:0]    cnt_q;
  logic [15:0]    dist_q, pulse_q;

  logic           needs_out, pop, fin;
  logic [7:0]     p;
  logic           acc, done;
  logic [SPW-1:0] base;
  logic [15:0]    w16, off;
  logic           dist_hit, pulse_hit;
  logic [ASW-1:0] addr, sum;
  logic           wr_en, rd_ok;

  assign needs_out = q_op_i.has_end || q_op_i.is_read;
  assign pop = q_valid_i && (!needs_out || !out_valid_q || out_ready_i);
  assign q_pop_o = pop;
  assign fin = pop && q_op_i.has_end && q_op_i.is_long;

  always_comb begin
    // a first sub-packet restarts assembly at index 1
    p    = (q_op_i.part_num == 8'd1) ? 8'd1 : exp_q;
    acc  = (q_op_i.spot_total != 16'd0) && (p != 8'd0) && (p == q_op_i.part_num);
    base = (q_op_i.part_num == 8'd1) ? '0 : spots_q;
    w16  = {1'b0, q_op_i.word_idx};
    dist_hit  = w16 < q_op_i.spot_total;
    pulse_hit = !dist_hit && q_op_i.is_type1 &&
                ({1'b0, w16} < {q_op_i.spot_total, 1'b0});
    off   = dist_hit ? w16 : (w16 - q_op_i.spot_total);
    addr  = ASW'(base) + ASW'(off);
    wr_en = pop && q_op_i.has_word && acc && (dist_hit || pulse_hit) &&
            (addr < ASW'(SPOT_DEPTH));
    sum   = ASW'(base) + ASW'(q_op_i.spot_total);
    rd_ok = (32'(q_op_i.read_idx) < SPOT_DEPTH);
  end

  always_comb begin
    exp_d   = exp_q;
    spots_d = spots_q;
    start_d = start_q;
    step_d  = step_q;
    msgs_d  = msgs_q;
    gaps_d  = gaps_q;
    prev_d  = prev_q;
    first_d = first_q;
    done    = 1'b0;
    if (fin) begin
      if (q_op_i.spot_total != 16'd0) begin
        if (q_op_i.part_num == 8'd1) begin
          start_d = q_op_i.first_angle;
          spots_d = '0;
        end
        if (acc) begin
          spots_d = (sum > ASW'(SPOT_DEPTH)) ? SPW'(SPOT_DEPTH) : sum[SPW-1:0];
          step_d  = q_op_i.delta_angle;
          if (p == q_op_i.total_parts) begin
            done  = 1'b1;
            exp_d = 8'd0;
          end else begin
            exp_d = p + 8'd1;
          end
        end
      end
      msgs_d = msgs_q + 32'd1;
      if (first_q) first_d = 1'b0;
      else if (q_op_i.sequence_num - prev_q != 16'd1) gaps_d = gaps_q + 32'd1;
      prev_d = q_op_i.sequence_num;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (dist_hit) dist_mem[addr[AW-1:0]] <= q_op_i.word;
      else pulse_mem[addr[AW-1:0]] <= q_op_i.word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && needs_out) begin
      if (q_op_i.is_read && rd_ok) begin
        dist_q  <= dist_mem[AW'(q_op_i.read_idx)];
        pulse_q <= pulse_mem[AW'(q_op_i.read_idx)];
      end else begin
        dist_q  <= '0;
        pulse_q <= '0;
      end
      kind_q <= q_op_i.is_read ? RESP_SPOT : RESP_STATUS;
      done_q <= done && !q_op_i.is_read;
      asm_q  <= fin && acc;
      tot_q  <= msgs_d;
      lost_q <= gaps_d;
      st_q   <= start_d;
      sp_q   <= step_d;
      cnt_q  <= 12'(spots_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= '0;
      spots_q     <= '0;
      start_q     <= '0;
      step_q      <= '0;
      msgs_q      <= '0;
      gaps_q      <= '0;
      prev_q      <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      exp_q   <= exp_d;
      spots_q <= spots_d;
      start_q <= start_d;
      step_q  <= step_d;
      msgs_q  <= msgs_d;
      gaps_q  <= gaps_d;
      prev_q  <= prev_d;
      first_q <= first_d;
      if (pop && needs_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign resp_kind_o      = kind_q;
  assign frame_done_o     = done_q;
  assign assembled_o      = asm_q;
  assign total_messages_o = tot_q;
  assign lost_messages_o  = lost_q;
  assign start_angle_o    = st_q;
  assign step_angle_o     = sp_q;
  assign spot_count_o     = cnt_q;
  assign distance_o       = dist_q;
  assign pulse_width_o    = pulse_q;

  a_spots_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(spots_q) <= SPOT_DEPTH) else $error("frame spot count above depth");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && needs_out) |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending result");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && done) |=> (exp_q == 8'd0)) else $error("expected part not cleared");

endmodule
`default_nettype wire

[rtl/lidar_scan_packet_reassembler.sv]
// Lidar scan-packet reassembler.
// Input channel (in_valid_i/in_ready_o): each request is either one message
// byte (req_type_i = 0, with last_byte_i marking the end of a message) or a
// read of a stored spot (req_type_i = 1, spot_index_i selects it).
// Output channel (out_valid_o/out_ready_i): one status result per finished
// message and one spot result per read; other bytes give nothing.
// The parser front end captures header fields and pairs data bytes into
// words; a two-entry queue feeds the frame engine, which judges acceptance,
// writes the distance and pulse stores and keeps the frame and counters.
// Throughput: one request per cycle while the queue has room. A taken request
// is written into the queue, then the registered result / memory read port
// loads from the queue head; requests already waiting in the queue are served
// first.
// A full output register stalls a result-giving request at the queue head and
// those behind it; byte writes at the head keep draining, and the front end takes requests while the
// queue has room.
// Reset clears all counters and header and frame state and marks the next
// message as the first for the sequence check. The spot stores are not
// cleared; reading a never-written spot returns arbitrary data.
`default_nettype none
module lidar_scan_packet_reassembler
  import lspr_pkg::*;
#(
  parameter int unsigned SPOT_DEPTH   = SpotDepthDefault,
  parameter int unsigned HEADER_BYTES = HeaderBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [10:0] spot_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             resp_kind_o,
  output logic             frame_done_o,
  output logic             assembled_o,
  output logic [31:0]      total_messages_o,
  output logic [31:0]      lost_messages_o,
  output logic signed [31:0] start_angle_o,
  output logic signed [31:0] step_angle_o,
  output logic [11:0]      spot_count_o,
  output logic [15:0]      distance_o,
  output logic [15:0]      pulse_width_o
);

  // front end to queue
  logic push, q_ready;
  op_t  push_op;
  // queue to frame engine
  logic pop, q_valid;
  op_t  head_op;

  lspr_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .data_byte_i,
    .last_byte_i, .spot_index_i,
    .q_ready_i(q_ready), .q_push_o(push), .q_op_o(push_op)
  );

  lspr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_op), .ready_o(q_ready),
    .pop_i(pop), .valid_o(q_valid), .data_o(head_op)
  );

  lspr_back #(.SPOT_DEPTH(SPOT_DEPTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_op_i(head_op), .q_pop_o(pop),
    .out_valid_o, .out_ready_i, .resp_kind_o, .frame_done_o, .assembled_o,
    .total_messages_o, .lost_messages_o, .start_angle_o, .step_angle_o,
    .spot_count_o, .distance_o, .pulse_width_o
  );

endmodule
`default_nettype wire

[bench/tb_lidar_scan_packet_reassembler.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_lidar_scan_packet_reassembler;
  import lspr_pkg::*;

  localparam int unsigned DEPTH = 2048;
  localparam int unsigned HDR   = 27;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = REQ_BYTE;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic [10:0] spot_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        resp_kind_o, frame_done_o, assembled_o;
  logic [31:0] total_messages_o, lost_messages_o;
  logic signed [31:0] start_angle_o, step_angle_o;
  logic [11:0] spot_count_o;
  logic [15:0] distance_o, pulse_width_o;

  lidar_scan_packet_reassembler dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    logic        req;
    logic [7:0]  b;
    logic        last;
    logic [10:0] idx;
  } request_t;

  typedef struct {
    logic        kind;
    logic        done;
    logic        acc;
    logic [31:0] msgs;
    logic [31:0] gaps;
    logic [31:0] sa;
    logic [31:0] st;
    logic [11:0] cnt;
    logic [15:0] dist_w;
    logic [15:0] pw;
  } status_t;

  request_t pending_reqs[$];
  status_t  expected_status[$];
  int unsigned n_pushed = 0, n_taken = 0, n_errors = 0;
  bit drv_calm = 1'b0, sink_calm = 1'b0;

  // Shadow copy of the parser and frame state.
  int unsigned pos, m_kind, m_seq, m_total, m_part, m_spots, m_first, m_delta;
  int unsigned hold_hi, next_part, f_spots, f_start, f_step;
  int unsigned msg_cnt, gap_cnt, prev_seq;
  bit          first_msg = 1'b1;
  logic [15:0] dist_mem[DEPTH];
  logic [15:0] pulse_mem[DEPTH];
  bit          dist_ok[DEPTH];
  bit          pulse_ok[DEPTH];

  function automatic int unsigned judged_part();
    return (m_part == 1) ? 1 : next_part;
  endfunction

  function automatic void store_word(int unsigned k, int unsigned b);
    int unsigned w, base, addr;
    if ((k & 1) == 0) begin
      hold_hi = b;
      return;
    end
    if (!(m_spots != 0 && judged_part() != 0 && judged_part() == m_part)) return;
    w = k >> 1;
    base = (m_part == 1) ? 0 : f_spots;
    if (w < m_spots) begin
      addr = base + w;
      if (addr < DEPTH) begin
        dist_mem[addr] = {hold_hi[7:0], b[7:0]};
        dist_ok[addr] = 1'b1;
      end
    end else if (m_kind == 1 && w < 2 * m_spots) begin
      addr = base + w - m_spots;
      if (addr < DEPTH) begin
        pulse_mem[addr] = {hold_hi[7:0], b[7:0]};
        pulse_ok[addr] = 1'b1;
      end
    end
  endfunction

  // Advance the shadow state by one accepted request and queue its result, if it gives one.
  function automatic void predict_status(request_t r);
    status_t s;
    int unsigned p, sum;
    s.kind = RESP_STATUS; s.done = 1'b0; s.acc = 1'b0; s.dist_w = '0; s.pw = '0;
    if (r.req == REQ_READ) begin
      s.kind = RESP_SPOT;
      s.dist_w = dist_mem[r.idx];
      s.pw = pulse_mem[r.idx];
    end else begin
      if (pos < 16'hFFFF) begin
        case (pos)
          0: m_kind = r.b;
          9, 10: m_seq = ((m_seq << 8) | r.b) & 16'hFFFF;
          11: m_total = r.b;
          12: m_part = r.b;
          15, 16: m_spots = ((m_spots << 8) | r.b) & 16'hFFFF;
          17, 18, 19, 20: m_first = (m_first << 8) | r.b;
          21, 22, 23, 24: m_delta = (m_delta << 8) | r.b;
          default: ;
        endcase
        if (pos >= HDR) store_word(pos - HDR, r.b);
      end
      if (!r.last) begin
        if (pos < 16'hFFFF) pos++;
        return;
      end
      if (pos >= HDR) begin
        if (m_spots != 0) begin
          p = judged_part();
          if (m_part == 1) begin
            f_start = m_first;
            f_spots = 0;
          end
          if (p != 0 && p == m_part) begin
            sum = f_spots + m_spots;
            s.acc = 1'b1;
            f_spots = (sum > DEPTH) ? DEPTH : sum;
            f_step = m_delta;
            if (p == m_total) begin
              s.done = 1'b1;
              next_part = 0;
            end else begin
              next_part = (p + 1) & 8'hFF;
            end
          end
        end
        msg_cnt++;
        if (first_msg) first_msg = 1'b0;
        else if (((m_seq - prev_seq) & 16'hFFFF) != 1) gap_cnt++;
        prev_seq = m_seq;
      end
      pos = 0;
    end
    s.msgs = msg_cnt; s.gaps = gap_cnt; s.sa = f_start; s.st = f_step;
    s.cnt = f_spots[11:0];
    expected_status.push_back(s);
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // Driver: change inputs at the falling edge; drop a request once taken.
  bit taken_flag = 1'b0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_status('{req_type_i, data_byte_i, last_byte_i, spot_index_i});
      n_taken++;
      taken_flag = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    request_t r;
    bit       busy;
    if (rst_ni) begin
      busy = in_valid_i && !taken_flag;
      taken_flag = 1'b0;
      if (!busy) begin
        if (pending_reqs.size() > 0 && (drv_calm || $urandom_range(99) >= 26)) begin
          r = pending_reqs.pop_front();
          req_type_i <= r.req;
          data_byte_i <= r.b;
          last_byte_i <= r.last;
          spot_index_i <= r.idx;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= sink_calm || ($urandom_range(99) >= 26);
    end
  end

  // Monitor: check each result against the oldest expectation.
  always @(posedge clk_i) begin
    status_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status.size() == 0) begin
        flag_mismatch("unexpected result", 0, 0);
      end else begin
        e = expected_status.pop_front();
        if (resp_kind_o !== e.kind) flag_mismatch("resp_kind", resp_kind_o, e.kind);
        if (frame_done_o !== e.done) flag_mismatch("frame_done", frame_done_o, e.done);
        if (assembled_o !== e.acc) flag_mismatch("assembled", assembled_o, e.acc);
        if (total_messages_o !== e.msgs) flag_mismatch("total_messages", total_messages_o, e.msgs);
        if (lost_messages_o !== e.gaps) flag_mismatch("lost_messages", lost_messages_o, e.gaps);
        if (start_angle_o !== e.sa) flag_mismatch("start_angle", start_angle_o, e.sa);
        if (step_angle_o !== e.st) flag_mismatch("step_angle", step_angle_o, e.st);
        if (spot_count_o !== e.cnt) flag_mismatch("spot_count", spot_count_o, e.cnt);
        if (distance_o !== e.dist_w) flag_mismatch("distance", distance_o, e.dist_w);
        if (pulse_width_o !== e.pw) flag_mismatch("pulse_width", pulse_width_o, e.pw);
      end
    end
  end

  task automatic add_req(logic req, logic [7:0] b, logic last, logic [10:0] idx);
    pending_reqs.push_back('{req, b, last, idx});
    n_pushed++;
  endtask

  // Read a spot whose distance and pulse are both known; skip if none is found in 40 random tries.
  task automatic add_read();
    int unsigned idx;
    for (int t = 0; t < 40; t++) begin
      idx = $urandom_range(DEPTH - 1);
      if (dist_ok[idx] && pulse_ok[idx]) begin
        add_req(REQ_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), 11'(idx));
        return;
      end
    end
  endtask

  // Queue one message: header, 'words' spot words, then 'extra' junk bytes.
  task automatic send_msg(int unsigned kind, int unsigned seqn, int unsigned tot,
                          int unsigned part, int unsigned nsp, int unsigned words,
                          int unsigned extra, int unsigned fa, int unsigned da);
    int unsigned len, b;
    len = HDR + 2 * words + extra;
    for (int unsigned i = 0; i < len; i++) begin
      b = $urandom_range(255);
      case (i)
        0: b = kind;
        9: b = seqn[15:8];
        10: b = seqn[7:0];
        11: b = tot;
        12: b = part;
        15: b = nsp[15:8];
        16: b = nsp[7:0];
        17: b = fa[31:24];
        18: b = fa[23:16];
        19: b = fa[15:8];
        20: b = fa[7:0];
        21: b = da[31:24];
        22: b = da[23:16];
        23: b = da[15:8];
        24: b = da[7:0];
        default: ;
      endcase
      add_req(REQ_BYTE, 8'(b), i == len - 1, 11'($urandom_range(2047)));
    end
  endtask

  task automatic send_short(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      add_req(REQ_BYTE, 8'($urandom_range(255)), i == len - 1,
              11'($urandom_range(2047)));
  endtask

  // Hold off until every request has been taken and every result has come.
  task automatic drain();
    wait (n_taken == n_pushed && expected_status.size() == 0);
  endtask

  initial begin
    int unsigned seqn, kind, tot, nsp, full, words, start_n, part, calm_phase;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, short messages, overflow, odd acceptance paths.
    seqn = 16'hFFFE;
    send_short(1);
    send_short(HDR);
    send_msg(1, seqn++, 1, 1, 4, 8, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_msg(0, seqn++, 2, 1, 3, 3, 5, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_msg(1, seqn++, 2, 2, 2, 1, 0, 32'h0, 32'h8000_0000);
    send_msg(0, seqn + 3, 3, 2, 2, 2, 0, 1, 1);
    send_msg(1, seqn++, 255, 0, 2, 4, 0, 5, 6);
    send_msg(1, seqn++, 1, 1, 0, 0, 4, 7, 8);
    // Overflow: first part claims nearly the whole depth, second runs past it.
    send_msg(1, seqn++, 2, 1, 2040, 2, 0, 9, 10);
    send_msg(1, seqn++, 2, 2, 20, 40, 0, 11, 12);
    send_msg(2, seqn++, 1, 1, 1, 1, 0, 13, 14);
    drain();
    for (int i = 0; i < 6; i++) add_read();
    // Trailing bytes after the last needed word are ignored.
    send_msg(0, seqn++, 1, 1, 3, 3, 40, 15, 16);
    drain();

    // Random: mostly well-formed frames, with broken parts and noise.
    start_n = n_pushed;
    calm_phase = 0;
    while (n_pushed - start_n < 1550) begin
      // one long stretch with neither side idling
      if (calm_phase == 0 && n_pushed - start_n >= 500) begin
        drain();
        drv_calm = 1'b1;
        sink_calm = 1'b1;
        calm_phase = 1;
      end else if (calm_phase == 1 && n_pushed - start_n >= 800) begin
        drain();
        drv_calm = 1'b0;
        sink_calm = 1'b0;
        calm_phase = 2;
      end
      tot = $urandom_range(4, 1);
      if ($urandom_range(19) == 0) tot = $urandom_range(255);
      kind = ($urandom_range(9) < 5) ? 1 : (($urandom_range(9) < 8) ? 0 : $urandom_range(255));
      for (int unsigned k = 1; k <= tot && k <= 5; k++) begin
        nsp = ($urandom_range(19) == 0) ? 0 : $urandom_range(8, 1);
        full = (kind == 1) ? 2 * nsp : nsp;
        words = ($urandom_range(9) == 0) ? $urandom_range(full) : full;
        part = ($urandom_range(14) == 0) ? $urandom_range(255) : k;
        if ($urandom_range(24) == 0) seqn += $urandom_range(3, 1);
        send_msg(kind, seqn++, tot, part, nsp, words,
                 ($urandom_range(7) == 0) ? $urandom_range(5, 1) : 0,
                 $urandom, $urandom);
        if ($urandom_range(3) == 0) add_read();
      end
      if ($urandom_range(15) == 0) send_short($urandom_range(HDR, 1));
      if ($urandom_range(30) == 0) drain();
    end
    drv_calm = 1'b0;
    sink_calm = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

[lidar_scan_packet_reassembler.f]
rtl/lspr_pkg.sv
rtl/lspr_front.sv
rtl/lspr_queue.sv
rtl/lspr_back.sv
rtl/lidar_scan_packet_reassembler.sv
bench/tb_lidar_scan_packet_reassembler.sv
